>>> src/cssp_pkg.sv
// package for the clip stack scissor planner: types, codes and widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cssp_pkg;

  localparam int unsigned ClipDepth = 16;
  localparam int unsigned DepthW    = $clog2(ClipDepth + 1);
  localparam int unsigned IdxW      = (ClipDepth > 1) ? $clog2(ClipDepth) : 1;

  // command kinds
  localparam logic [2:0] KindPush  = 3'd0;
  localparam logic [2:0] KindPop   = 3'd1;
  localparam logic [2:0] KindQuad  = 3'd2;
  localparam logic [2:0] KindDebug = 3'd5;

  // configuration register indexes
  localparam logic [2:0] RegVpX = 3'd0;
  localparam logic [2:0] RegVpY = 3'd1;
  localparam logic [2:0] RegVpW = 3'd2;
  localparam logic [2:0] RegVpH = 3'd3;
  localparam logic [2:0] RegSfW = 3'd4;
  localparam logic [2:0] RegSfH = 3'd5;

  // divider operand widths: numerator up to 26b * 15b, denominator 23b
  localparam int unsigned NumW = 41;
  localparam int unsigned DenW = 23;
  localparam int unsigned QW   = 41;

  typedef struct packed {
    logic             start;
    logic [NumW-1:0]  num;   // magnitude
    logic [DenW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QW-1:0]    quot;
    logic             rem_nz;
  } div_rsp_t;

  typedef enum logic [3:0] {
    StIdle, StClip, StCheck, StMul, StDivGo, StDivWait, StFix, StOut
  } state_e;

endpackage
`default_nettype wire

>>> src/clip_stack_scissor_planner.sv
// top level of the clip stack scissor planner: sequencer, stack, shared divider
// depends on cssp_pkg, cssp_stack, cssp_divider
//
// channel   dir  handshake           payload
// s_axis    in   tvalid/tready       tdata: kind, rect_x/y/width/height, color_visible
// m_axis    out  tvalid/tready       tdata: status .. command_index
// cfg       in   cfg_we_i            cfg_index_i, cfg_data_i
//
// push and pop pass StClip and StCheck before the next beat can be accepted; a draw
// discarded before the scissor also passes StOut, and a draw that reaches the scissor
// runs the shared one-bit-per-cycle divider once per scissor edge
// reset clears the stack depth, overflow count and command counter at once
// the sequencer holds the result in the output register until it is taken; a new
// beat is accepted only when the previous command is finished
`timescale 1ns / 1ps
`default_nettype none
module clip_stack_scissor_planner (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [23:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // kind[2:0] rect_x[26:3] rect_y[50:27] rect_width[74:51] rect_height[98:75]
  // color_visible[99], zero pad to 104
  input  wire logic [103:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[0] batch_kind[2:1] was_clipped[3] clipped_x[27:4] clipped_y[51:28]
  // clipped_width[74:52] clipped_height[97:75] scissor_x[112:98] scissor_y[127:113]
  // scissor_width[142:128] scissor_height[157:143] command_index[189:158], pad to 192
  output logic [191:0]      m_axis_tdata
);
  import cssp_pkg::*;

  // configuration
  logic signed [23:0] vp_x_q, vp_y_q, vp_w_q, vp_h_q;
  logic [14:0]        sf_w_q, sf_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_x_q <= '0; vp_y_q <= '0; vp_w_q <= '0; vp_h_q <= '0;
      sf_w_q <= '0; sf_h_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegVpX:  vp_x_q <= cfg_data_i;
        RegVpY:  vp_y_q <= cfg_data_i;
        RegVpW:  vp_w_q <= cfg_data_i;
        RegVpH:  vp_h_q <= cfg_data_i;
        RegSfW:  sf_w_q <= cfg_data_i[14:0];
        RegSfH:  sf_h_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // state
  state_e             state_q, state_d;
  logic [DepthW-1:0]  depth_q, depth_d;
  logic [15:0]        ovf_q, ovf_d;
  logic [31:0]        cnt_q, cnt_d;

  // command registers (26-bit signed working width holds edges exactly)
  logic [2:0]         kind_q;
  logic               vis_q;
  logic signed [25:0] rx_q, ry_q, rw_q, rh_q;
  logic [31:0]        idx_q;
  // active clip and clipped box, edges x0,y0,x1,y1
  logic signed [25:0] kx0_q, ky0_q, kx1_q, ky1_q;
  logic [1:0]         edge_q;
  logic [14:0]        px_q [4];
  logic signed [41:0] prod_q;
  logic [191:0]       out_q;
  logic               ovalid_q;
  logic               disc_fields_q;

  // stack
  logic [95:0] top_rd;
  logic        st_we;
  logic [95:0] st_wd;

  cssp_stack u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (depth_q[IdxW-1:0]),
    .wdata_i (st_wd),
    .raddr_i (IdxW'(depth_q - 1'b1)),
    .rdata_o (top_rd)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  cssp_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // active clip: viewport meet top entry
  logic signed [25:0] vx0, vy0, vx1, vy1, tx0, ty0, tx1, ty1;
  logic signed [25:0] cx0, cy0, cx1, cy1, ax0, ay0, ax1, ay1;
  logic               c_empty, a_empty, discard_pre;

  always_comb begin
    vx0 = 26'(vp_x_q); vy0 = 26'(vp_y_q);
    vx1 = 26'(vp_x_q) + 26'(vp_w_q);
    vy1 = 26'(vp_y_q) + 26'(vp_h_q);
    tx0 = 26'($signed(top_rd[23:0]));
    ty0 = 26'($signed(top_rd[47:24]));
    tx1 = tx0 + 26'($signed(top_rd[71:48]));
    ty1 = ty0 + 26'($signed(top_rd[95:72]));
    cx0 = vx0; cy0 = vy0; cx1 = vx1; cy1 = vy1;
    if (depth_q != '0) begin
      // meet: empty gives larger origin with zero extent
      cx0 = (vx0 > tx0) ? vx0 : tx0;
      cy0 = (vy0 > ty0) ? vy0 : ty0;
      cx1 = (vx1 < tx1) ? vx1 : tx1;
      cy1 = (vy1 < ty1) ? vy1 : ty1;
      if (cx1 <= cx0 || cy1 <= cy0) begin
        cx1 = cx0; cy1 = cy0;
      end
    end
    // command meet active clip
    ax0 = (rx_q > cx0) ? rx_q : cx0;
    ay0 = (ry_q > cy0) ? ry_q : cy0;
    ax1 = ((rx_q + rw_q) < cx1) ? (rx_q + rw_q) : cx1;
    ay1 = ((ry_q + rh_q) < cy1) ? (ry_q + rh_q) : cy1;
    c_empty = (ax1 <= ax0) || (ay1 <= ay0);
    a_empty = c_empty;
    if (c_empty) begin
      ax1 = ax0; ay1 = ay0;
    end
    discard_pre = !vis_q || rw_q <= 0 || rh_q <= 0 || vp_w_q <= 0 || vp_h_q <= 0
                  || sf_w_q == '0 || sf_h_q == '0;
  end

  // scissor edge operands
  logic signed [25:0] e_v, e_o;
  logic [14:0]        e_s;
  logic [22:0]        e_d;
  logic               e_up, p_neg, q_adj;
  logic [QW:0]        q_mag;
  logic signed [QW+1:0] p_val;
  logic [14:0]        p_clamp;

  always_comb begin
    case (edge_q)
      2'd0: begin e_v = kx0_q; e_o = 26'(vp_x_q); e_s = sf_w_q; e_d = vp_w_q[22:0];
                  e_up = 1'b0; end
      2'd1: begin e_v = ky0_q; e_o = 26'(vp_y_q); e_s = sf_h_q; e_d = vp_h_q[22:0];
                  e_up = 1'b0; end
      2'd2: begin e_v = kx1_q; e_o = 26'(vp_x_q); e_s = sf_w_q; e_d = vp_w_q[22:0];
                  e_up = 1'b1; end
      default: begin e_v = ky1_q; e_o = 26'(vp_y_q); e_s = sf_h_q; e_d = vp_h_q[22:0];
                  e_up = 1'b1; end
    endcase
    p_neg = prod_q[41];
    // floor for lower edge, ceil for upper: round magnitude away/toward by sign
    q_adj = drsp.rem_nz && (p_neg != e_up);
    q_mag = {1'b0, drsp.quot} + (QW+1)'(q_adj);
    p_val = p_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    if (p_val < 0) p_clamp = '0;
    else if (p_val > $signed({{(QW-13){1'b0}}, e_s})) p_clamp = e_s;
    else p_clamp = p_val[14:0];
  end

  logic signed [41:0] prod_abs;
  assign prod_abs = prod_q[41] ? -prod_q : prod_q;

  // final result fields
  logic [14:0] sw, sh;
  logic        wc;
  assign sw = px_q[2] - px_q[0];
  assign sh = px_q[3] - px_q[1];
  assign wc = (kx0_q > rx_q) || (ky0_q > ry_q) || (kx1_q < rx_q + rw_q)
              || (ky1_q < ry_q + rh_q);

  logic disc_fields;
  logic [191:0] out_d;
  logic ovalid_d, load;

  always_comb begin
    state_d  = state_q;
    depth_d  = depth_q;
    ovf_d    = ovf_q;
    cnt_d    = cnt_q;
    st_we    = 1'b0;
    st_wd    = {24'(ay1 - ay0), 24'(ax1 - ax0), ay0[23:0], ax0[23:0]};
    dreq     = '0;
    load     = 1'b0;
    out_d    = out_q;
    ovalid_d = ovalid_q;
    disc_fields = 1'b0;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    s_axis_tready = (state_q == StIdle);
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          load    = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = StClip;
        end
      end
      StClip: state_d = StCheck; // stack read settles
      StCheck: begin
        state_d = StIdle;
        if (kind_q == KindPush) begin
          if (depth_q < DepthW'(ClipDepth)) begin
            st_we   = 1'b1;
            depth_d = depth_q + 1'b1;
          end else if (ovf_q != 16'hFFFF) begin
            ovf_d = ovf_q + 1'b1;
          end
        end else if (kind_q == KindPop) begin
          if (ovf_q != '0) ovf_d = ovf_q - 1'b1;
          else if (depth_q != '0) depth_d = depth_q - 1'b1;
        end else if (kind_q <= KindDebug) begin
          if (discard_pre || a_empty) begin
            disc_fields = 1'b1;
            state_d = StOut;
          end else begin
            state_d = StMul;
          end
        end
      end
      StMul:   state_d = StDivGo;
      StDivGo: begin
        dreq.start = 1'b1;
        dreq.num   = prod_abs[NumW-1:0];
        dreq.den   = e_d;
        state_d    = StDivWait;
      end
      StDivWait: if (drsp.done) state_d = (edge_q == 2'd3) ? StFix : StMul;
      StFix: begin
        if (px_q[2] <= px_q[0] || px_q[3] <= px_q[1]) disc_fields = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          out_d = '0;
          out_d[2:1] = 2'(kind_q - KindQuad);
          out_d[189:158] = idx_q;
          if (disc_fields_q) begin
            out_d[0] = 1'b1;
          end else begin
            out_d[3]       = wc;
            out_d[27:4]    = kx0_q[23:0];
            out_d[51:28]   = ky0_q[23:0];
            out_d[74:52]   = 23'(kx1_q - kx0_q);
            out_d[97:75]   = 23'(ky1_q - ky0_q);
            out_d[112:98]  = px_q[0];
            out_d[127:113] = px_q[1];
            out_d[142:128] = sw;
            out_d[157:143] = sh;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      depth_q  <= '0;
      ovf_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      edge_q   <= '0;
      disc_fields_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      depth_q  <= depth_d;
      ovf_q    <= ovf_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      if (load) begin
        edge_q <= '0;
        disc_fields_q <= 1'b0;
      end
      if (disc_fields) disc_fields_q <= 1'b1;
      if (state_q == StDivWait && drsp.done) edge_q <= edge_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load) begin
      kind_q <= s_axis_tdata[2:0];
      rx_q   <= 26'($signed(s_axis_tdata[26:3]));
      ry_q   <= 26'($signed(s_axis_tdata[50:27]));
      rw_q   <= 26'($signed(s_axis_tdata[74:51]));
      rh_q   <= 26'($signed(s_axis_tdata[98:75]));
      vis_q  <= s_axis_tdata[99];
      idx_q  <= cnt_q;
    end
    if (state_q == StCheck) begin
      kx0_q <= ax0; ky0_q <= ay0; kx1_q <= ax1; ky1_q <= ay1;
    end
    if (state_q == StMul) begin
      prod_q <= 42'(e_v - e_o) * $signed({1'b0, e_s});
    end
    if (state_q == StDivWait && drsp.done) px_q[edge_q] <= p_clamp;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

>>> src/cssp_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on cssp_pkg
`timescale 1ns / 1ps
`default_nettype none
module cssp_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  cssp_pkg::div_req_t     req_i,
  output cssp_pkg::div_rsp_t     rsp_o
);
  import cssp_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;
  logic [DenW+1:0] diff;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DenW+1]) begin
        rem_d  = diff[DenW:0];
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quot_q;
  assign rsp_o.rem_nz = (rem_q != '0);
endmodule
`default_nettype wire

>>> src/cssp_stack.sv
// clip rectangle stack memory with registered read of the top entry
// depends on cssp_pkg
`timescale 1ns / 1ps
`default_nettype none
module cssp_stack (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [cssp_pkg::IdxW-1:0] waddr_i,
  input  wire logic [95:0]            wdata_i,
  input  wire logic [cssp_pkg::IdxW-1:0] raddr_i,
  output logic [95:0]                 rdata_o
);
  import cssp_pkg::*;

  logic [95:0] mem_q [ClipDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> src/cssp_checker.sv
// port-level checker for the clip stack scissor planner, bound to the top level
// depends on clip_stack_scissor_planner
`timescale 1ns / 1ps
`default_nettype none
module cssp_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [191:0] m_axis_tdata
);
  // the block takes no new beat in the cycle right after one
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a discarded result has zero scissor fields
  a_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[157:98] == '0)
    else $error("discard with scissor");

  // an emitted result has a nonzero scissor width
  a_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[142:128] != '0)
    else $error("empty scissor emitted");
endmodule

bind clip_stack_scissor_planner cssp_checker u_cssp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
